// ----- design/pll_pkg.sv -----
// ----------------------------------------------------------------------------
// pll_pkg
// Shared types and constants of the positional linked list engine.
// ----------------------------------------------------------------------------
package pll_pkg;

  localparam int unsigned DefCapacity = 32;

  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_PREPEND = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_LENGTH  = 3'd3,
    ACT_DUMP    = 3'd4,
    ACT_DELETE  = 3'd5,
    ACT_RSVD6   = 3'd6,
    ACT_RSVD7   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LINK,
    S_DUMP,
    S_DONE
  } state_e;

endpackage

// ----- design/pll_ram.sv -----
// ----------------------------------------------------------------------------
// pll_ram
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module pll_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/positional_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_linked_list_engine
// Linked list of signed values in node memory; links walked one node a cycle.
// Length, prepend, append to an empty list and rejected requests go straight
// to the result; append walks to the tail, insert after p walks to node p and
// delete at p walks to node p-1 (at the head it only reads the head's link).
// Dump emits one element per cycle once the head is read. busy stays high
// through the last result; the next transfer can be taken the cycle after.
// Reset: head null, all nodes free, count zero; node memories not cleared.
// ----------------------------------------------------------------------------
module positional_linked_list_engine
  import pll_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [6:0]  position_i,
  input  logic signed [31:0] value_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic signed [31:0] element_value_o,
  output logic [6:0]  element_index_o,
  output logic [6:0]  element_count_o,
  output logic        last_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned LW = $clog2(Capacity + 1);
  localparam logic [LW-1:0] Nil = LW'(Capacity);

  state_e state_q, state_d;
  action_e act_q, act_d;
  logic [31:0] val_q, val_d;
  logic [LW-1:0] head_q, head_d;
  logic [Capacity-1:0] free_q, free_d;
  logic [6:0] cnt_q, cnt_d;
  logic [LW-1:0] cur_q, cur_d;   // node whose link is being read
  logic [LW-1:0] nn_q, nn_d;     // newly allocated node (previous node on delete)
  logic [6:0] step_q, step_d;
  logic [6:0] tgt_q, tgt_d;

  logic lwe, vwe;
  logic [AW-1:0] lwa, vwa, lra, vra;
  logic [LW-1:0] lwd, lrd;
  logic [31:0] vwd, vrd;

  pll_ram #(.Width(LW), .Depth(Capacity)) u_links (
    .clk_i, .we_i(lwe), .waddr_i(lwa), .wdata_i(lwd), .raddr_i(lra), .rdata_o(lrd));
  pll_ram #(.Width(32), .Depth(Capacity)) u_values (
    .clk_i, .we_i(vwe), .waddr_i(vwa), .wdata_i(vwd), .raddr_i(vra), .rdata_o(vrd));

  logic [LW-1:0] alloc;
  logic afull;
  always_comb begin
    alloc = Nil;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (free_q[i]) alloc = LW'(i);
    end
    afull = ~|free_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= Nil;
      free_q  <= '1;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; val_q <= val_d;
    cur_q <= cur_d; nn_q <= nn_d; step_q <= step_d; tgt_q <= tgt_d;
  end

  always_comb begin
    state_d = state_q; act_d = act_q; val_d = val_q;
    head_d = head_q; free_d = free_q; cnt_d = cnt_q;
    cur_d = cur_q; nn_d = nn_q; step_d = step_q; tgt_d = tgt_q;
    lwe = 1'b0; lwa = '0; lwd = '0; lra = cur_q[AW-1:0];
    vwe = 1'b0; vwa = '0; vwd = val_q; vra = cur_q[AW-1:0];
    busy = (state_q != S_IDLE);
    valid_o = 1'b0; status_o = ST_OK; element_value_o = '0;
    element_index_o = '0; element_count_o = cnt_q; last_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          act_d = action_e'(action_i); val_d = value_i;
          state_d = S_DONE; step_d = 7'd1; cur_d = head_q; nn_d = alloc;
          tgt_d = 7'(ST_OK);   // tgt holds status for the done cycle
          case (action_e'(action_i))
            ACT_APPEND: begin
              if (afull) tgt_d = 7'(ST_FULL);
              else if (cnt_q == 0) begin
                vwe = 1'b1; vwa = alloc[AW-1:0]; vwd = value_i;
                lwe = 1'b1; lwa = alloc[AW-1:0]; lwd = Nil;
                head_d = alloc; free_d[alloc[AW-1:0]] = 1'b0; cnt_d = cnt_q + 7'd1;
              end else begin
                tgt_d = cnt_q; state_d = S_WALK;
                lra = head_q[AW-1:0];
              end
            end
            ACT_PREPEND: begin
              if (afull) tgt_d = 7'(ST_FULL);
              else begin
                vwe = 1'b1; vwa = alloc[AW-1:0]; vwd = value_i;
                lwe = 1'b1; lwa = alloc[AW-1:0]; lwd = head_q;
                head_d = alloc; free_d[alloc[AW-1:0]] = 1'b0; cnt_d = cnt_q + 7'd1;
              end
            end
            ACT_INSERT: begin
              if (position_i == 0 || position_i > cnt_q) tgt_d = 7'(ST_BADPOS);
              else if (afull) tgt_d = 7'(ST_FULL);
              else begin
                tgt_d = position_i; state_d = S_WALK;
                lra = head_q[AW-1:0];
              end
            end
            ACT_DELETE: begin
              if (position_i == 0 || position_i > cnt_q) tgt_d = 7'(ST_BADPOS);
              else begin
                // walk to pos: when read of node pos-1 done, link gives victim
                tgt_d = position_i; state_d = S_WALK;
                lra = head_q[AW-1:0];
              end
            end
            ACT_DUMP: begin
              if (cnt_q == 0) tgt_d = 7'(ST_EMPTY);
              else begin
                state_d = S_DUMP;
                lra = head_q[AW-1:0]; vra = head_q[AW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // lrd = link of cur_q; cur_q is node at position step_q
        if (act_q == ACT_DELETE && tgt_q == 7'd1) begin
          head_d = lrd; free_d[cur_q[AW-1:0]] = 1'b1; cnt_d = cnt_q - 7'd1;
          tgt_d = 7'(ST_OK); state_d = S_DONE;
        end else if (act_q == ACT_DELETE && step_q == tgt_q - 7'd1) begin
          // prev=cur_q, victim=lrd; need victim's link
          nn_d = cur_q; cur_d = lrd; lra = lrd[AW-1:0]; state_d = S_LINK;
        end else if (step_q == tgt_q) begin
          // cur_q = prev for append/insert
          vwe = 1'b1; vwa = nn_q[AW-1:0];
          lwe = 1'b1; lwa = nn_q[AW-1:0];
          lwd = (act_q == ACT_APPEND) ? Nil : lrd;
          state_d = S_LINK;
        end else begin
          cur_d = lrd; lra = lrd[AW-1:0]; step_d = step_q + 7'd1;
        end
      end
      S_LINK: begin
        if (act_q == ACT_DELETE) begin
          lwe = 1'b1; lwa = nn_q[AW-1:0]; lwd = lrd;
          free_d[cur_q[AW-1:0]] = 1'b1; cnt_d = cnt_q - 7'd1;
        end else begin
          lwe = 1'b1; lwa = cur_q[AW-1:0]; lwd = nn_q;
          free_d[nn_q[AW-1:0]] = 1'b0; cnt_d = cnt_q + 7'd1;
        end
        tgt_d = 7'(ST_OK); state_d = S_DONE;
      end
      S_DUMP: begin
        valid_o = 1'b1; element_value_o = vrd; element_index_o = step_q;
        last_o = (step_q == cnt_q);
        cur_d = lrd; lra = lrd[AW-1:0]; vra = lrd[AW-1:0];
        step_d = step_q + 7'd1;
        if (step_q == cnt_q) state_d = S_IDLE;
      end
      S_DONE: begin
        valid_o = 1'b1; status_o = tgt_q[1:0]; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
